/* hdl/ffaa_pkg.sv */
// shared types and constants of the arena allocator
package ffaa_pkg;

  localparam logic [2:0] MODE_INIT  = 3'd0;
  localparam logic [2:0] MODE_ALLOC = 3'd1;
  localparam logic [2:0] MODE_FREE  = 3'd2;
  localparam logic [2:0] MODE_FILL  = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  localparam int unsigned HDR_BYTES  = 12;
  localparam int unsigned HDR_WRITES = 20;

  typedef struct packed {
    logic start;
    logic used;
  } ffaa_flag_t;

endpackage

/* hdl/ffaa_store.sv */
// arena byte memory and per-byte flag memory, one write and one read port each
module ffaa_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                clk_i,
  input  logic                byte_we_i,
  input  logic [AW-1:0]       byte_waddr_i,
  input  logic [7:0]          byte_wdata_i,
  input  logic                flag_we_i,
  input  logic [AW-1:0]       flag_waddr_i,
  input  ffaa_pkg::ffaa_flag_t flag_wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [7:0]          byte_rdata_o,
  output ffaa_pkg::ffaa_flag_t flag_rdata_o
);
  import ffaa_pkg::*;

  logic [7:0] byte_mem [DEPTH];
  ffaa_flag_t flag_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (byte_we_i) begin
      byte_mem[byte_waddr_i] <= byte_wdata_i;
    end
    byte_rdata_o <= byte_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (flag_we_i) begin
      flag_mem[flag_waddr_i] <= flag_wdata_i;
    end
    flag_rdata_o <= flag_mem[raddr_i];
  end

endmodule

/* hdl/first_fit_arena_allocator_core.sv */
// first-fit arena allocator: command sequencer over the arena memories
// for the read, init, free, alloc and fill commands;
// every scan walks the memory read port one byte per cycle, one command at a time
// after reset a clearing pass zeroes the arena, input stalled
module first_fit_arena_allocator_core #(
  parameter int unsigned ARENA_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [12:0] amount_i,
  input  logic [11:0] position_i,
  input  logic [7:0]  fill_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [12:0] result_value_o,
  output logic        failed_o
);
  import ffaa_pkg::*;

  localparam int unsigned AW = (ARENA_BYTES > 1) ? $clog2(ARENA_BYTES) : 1;
  localparam int unsigned CW = $clog2(ARENA_BYTES + 1);
  localparam int unsigned XW = ((CW > 13) ? CW : 13) + 1;
  localparam logic [AW-1:0] LAST = AW'(ARENA_BYTES - 1);
  localparam logic [XW-1:0] ARENA_X = XW'(ARENA_BYTES);
  localparam logic [XW-1:0] HDR_X = XW'(HDR_BYTES);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_CHK, S_ASCAN, S_ANEXT, S_PREV, S_FWD,
    S_FILL, S_HDR, S_MARK, S_OUT
  } state_e;

  state_e      state_q;
  logic [2:0]  mode_q;
  logic [12:0] amt_q;
  logic [7:0]  fb_q;
  logic [12:0] size_q;
  logic        init_cmd_q;
  logic [AW-1:0] scan_q, tag_q, s_q, e_q, pv_q, nx_q;
  logic        tvld_q, hp_q, hn_q, phase_q;
  logic [XW-1:0] run_q;
  logic [12:0] cnt_q;
  logic [3:0]  skip_q;
  logic [4:0]  hc_q;
  logic [12:0] res_q;
  logic        fail_q;
  logic        out_vld_q;
  logic [12:0] result_q;
  logic        failed_q;

  logic [7:0]  byte_rd;
  ffaa_flag_t  flag_rd;

  logic [XW-1:0] s_x, tag_x, pos_x, size_x, n_x, dim_x, run_n;
  logic [3:0]  fill_sk;
  logic        fill_wr, fwd_clr, is_alloc;
  logic [12:0] cnt_n;
  logic [XW-1:0] hdr_base, hdr_addr;
  logic [31:0] hdr_val;
  logic        hdr_en, hdr_we;
  logic [7:0]  hdr_byte;

  logic        byte_we, flag_we;
  logic [AW-1:0] byte_waddr, flag_waddr;
  logic [7:0]  byte_wdata;
  ffaa_flag_t  flag_wdata;

  assign s_x    = XW'(s_q);
  assign tag_x  = XW'(tag_q);
  assign pos_x  = XW'(position_i);
  assign size_x = XW'(size_q);
  assign n_x    = (size_x < ARENA_X) ? size_x : ARENA_X;
  assign dim_x  = XW'(amt_q) + HDR_X;
  assign run_n  = run_q + XW'(1);
  assign is_alloc = (mode_q == MODE_ALLOC);

  assign fill_sk = flag_rd.start ? 4'(HDR_BYTES) : skip_q;
  assign fill_wr = (state_q == S_FILL) && tvld_q && (fill_sk == 4'd0) && flag_rd.used;
  assign cnt_n   = cnt_q + 13'(fill_wr);
  assign fwd_clr = (state_q == S_FWD) && tvld_q && phase_q &&
                   ((tag_q == s_q) || (flag_rd.used && !flag_rd.start));

  // header word writes: three words of the new block (alloc only), then the two neighbor links
  always_comb begin
    hdr_base = s_x;
    hdr_val  = '0;
    hdr_en   = 1'b0;
    unique case (hc_q[4:2])
      3'd0: begin
        hdr_base = s_x;
        hdr_val  = hn_q ? 32'(nx_q) : 32'd0;
        hdr_en   = is_alloc;
      end
      3'd1: begin
        hdr_base = s_x + XW'(4);
        hdr_val  = hp_q ? 32'(pv_q) : 32'd0;
        hdr_en   = is_alloc;
      end
      3'd2: begin
        hdr_base = s_x + XW'(8);
        hdr_val  = 32'(amt_q);
        hdr_en   = is_alloc;
      end
      3'd3: begin
        hdr_base = XW'(pv_q);
        hdr_val  = is_alloc ? 32'(s_q) : (hn_q ? 32'(nx_q) : 32'd0);
        hdr_en   = hp_q;
      end
      3'd4: begin
        hdr_base = XW'(nx_q) + XW'(4);
        hdr_val  = is_alloc ? 32'(s_q) : (hp_q ? 32'(pv_q) : 32'd0);
        hdr_en   = hn_q;
      end
      default: begin
        hdr_en = 1'b0;
      end
    endcase
  end

  assign hdr_addr = hdr_base + XW'(hc_q[1:0]);
  assign hdr_byte = hdr_val[{hc_q[1:0], 3'b000} +: 8];
  assign hdr_we   = (state_q == S_HDR) && hdr_en && (hdr_addr < ARENA_X);

  always_comb begin
    byte_we    = 1'b0;
    byte_waddr = tag_q;
    byte_wdata = 8'd0;
    flag_we    = 1'b0;
    flag_waddr = tag_q;
    flag_wdata = '0;
    priority if (state_q == S_CLR) begin
      byte_we    = 1'b1;
      byte_waddr = scan_q;
      flag_we    = 1'b1;
      flag_waddr = scan_q;
    end else if (fwd_clr) begin
      byte_we = 1'b1;
      flag_we = 1'b1;
    end else if (fill_wr) begin
      byte_we    = 1'b1;
      byte_wdata = fb_q;
    end else if (hdr_we) begin
      byte_we    = 1'b1;
      byte_waddr = hdr_addr[AW-1:0];
      byte_wdata = hdr_byte;
    end else if (state_q == S_MARK) begin
      flag_we          = 1'b1;
      flag_waddr       = scan_q;
      flag_wdata.start = (scan_q == s_q);
      flag_wdata.used  = 1'b1;
    end else begin
      byte_we = 1'b0;
    end
  end

  ffaa_store #(
    .DEPTH (ARENA_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i        (clk_i),
    .byte_we_i    (byte_we),
    .byte_waddr_i (byte_waddr),
    .byte_wdata_i (byte_wdata),
    .flag_we_i    (flag_we),
    .flag_waddr_i (flag_waddr),
    .flag_wdata_i (flag_wdata),
    .raddr_i      (scan_q),
    .byte_rdata_o (byte_rd),
    .flag_rdata_o (flag_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      scan_q     <= '0;
      tvld_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      size_q     <= 13'd4096;
      init_cmd_q <= 1'b0;
      hc_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      tvld_q <= 1'b1;
      tag_q  <= scan_q;
      scan_q <= (state_q == S_PREV) ? scan_q - AW'(1) : scan_q + AW'(1);
      unique case (state_q)
        S_CLR: begin
          if (scan_q == LAST) begin
            state_q <= init_cmd_q ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          tvld_q <= 1'b0;
          if (in_valid_i) begin
            mode_q <= mode_i;
            amt_q  <= amount_i;
            fb_q   <= fill_byte_i;
            res_q  <= '0;
            fail_q <= 1'b0;
            state_q <= S_OUT;
            priority if (mode_i == MODE_INIT) begin
              scan_q     <= '0;
              init_cmd_q <= 1'b1;
              state_q    <= S_CLR;
            end else if (mode_i == MODE_ALLOC) begin
              if (n_x == '0) begin
                fail_q <= 1'b1;
              end else begin
                scan_q  <= '0;
                run_q   <= '0;
                hp_q    <= 1'b0;
                state_q <= S_ASCAN;
              end
            end else if (mode_i == MODE_FREE || mode_i == MODE_FILL) begin
              if (pos_x >= HDR_X && (pos_x - HDR_X) < ARENA_X) begin
                s_q     <= AW'(pos_x - HDR_X);
                scan_q  <= AW'(pos_x - HDR_X);
                state_q <= S_CHK;
              end
            end else if (mode_i == MODE_READ) begin
              if (pos_x < ARENA_X) begin
                scan_q  <= AW'(pos_x);
                state_q <= S_RD;
              end
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_RD: begin
          if (tvld_q) begin
            res_q   <= 13'(byte_rd);
            state_q <= S_OUT;
          end
        end
        S_CHK: begin
          if (tvld_q) begin
            tvld_q <= 1'b0;
            hp_q   <= 1'b0;
            hn_q   <= 1'b0;
            if (!flag_rd.start) begin
              state_q <= S_OUT;
            end else if (mode_q == MODE_FREE) begin
              if (s_q == '0) begin
                scan_q  <= s_q;
                phase_q <= 1'b1;
                state_q <= S_FWD;
              end else begin
                scan_q  <= s_q - AW'(1);
                state_q <= S_PREV;
              end
            end else if ((s_x + HDR_X) >= ARENA_X || amt_q == '0) begin
              state_q <= S_OUT;
            end else begin
              scan_q  <= AW'(s_x + HDR_X);
              skip_q  <= '0;
              cnt_q   <= '0;
              state_q <= S_FILL;
            end
          end
        end
        S_ASCAN: begin
          if (tvld_q) begin
            if (flag_rd.start) begin
              pv_q <= tag_q;
              hp_q <= 1'b1;
            end
            if (!flag_rd.used && run_n == dim_x) begin
              e_q    <= tag_q;
              s_q    <= AW'(tag_x + XW'(1) - dim_x);
              hn_q   <= 1'b0;
              hc_q   <= '0;
              tvld_q <= 1'b0;
              if (tag_q == LAST) begin
                state_q <= S_HDR;
              end else begin
                scan_q  <= tag_q + AW'(1);
                state_q <= S_ANEXT;
              end
            end else begin
              run_q <= flag_rd.used ? '0 : run_n;
              if (tag_x == n_x - XW'(1)) begin
                fail_q  <= 1'b1;
                state_q <= S_OUT;
              end
            end
          end
        end
        S_ANEXT: begin
          if (tvld_q) begin
            if (flag_rd.start) begin
              nx_q    <= tag_q;
              hn_q    <= 1'b1;
              state_q <= S_HDR;
            end else if (tag_q == LAST) begin
              state_q <= S_HDR;
            end
          end
        end
        S_PREV: begin
          if (tvld_q) begin
            if (flag_rd.start || tag_q == '0) begin
              pv_q    <= tag_q;
              hp_q    <= flag_rd.start;
              scan_q  <= s_q;
              tvld_q  <= 1'b0;
              phase_q <= 1'b1;
              state_q <= S_FWD;
            end
          end
        end
        S_FWD: begin
          hc_q <= '0;
          if (tvld_q) begin
            if (fwd_clr) begin
              if (tag_q == LAST) begin
                state_q <= S_HDR;
              end
            end else begin
              phase_q <= 1'b0;
              if (flag_rd.start) begin
                nx_q    <= tag_q;
                hn_q    <= 1'b1;
                state_q <= S_HDR;
              end else if (tag_q == LAST) begin
                state_q <= S_HDR;
              end
            end
          end
        end
        S_FILL: begin
          if (tvld_q) begin
            skip_q <= (fill_sk != 4'd0) ? fill_sk - 4'd1 : 4'd0;
            cnt_q  <= cnt_n;
            if ((fill_wr && cnt_n == amt_q) || tag_q == LAST) begin
              res_q   <= cnt_n;
              state_q <= S_OUT;
            end
          end
        end
        S_HDR: begin
          hc_q <= hc_q + 5'd1;
          if (hc_q == 5'(HDR_WRITES - 1)) begin
            if (is_alloc) begin
              scan_q  <= s_q;
              state_q <= S_MARK;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_MARK: begin
          if (scan_q == e_q) begin
            res_q   <= 13'(s_x + HDR_X);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_vld_q || !out_stall_i) begin
            out_vld_q  <= 1'b1;
            result_q   <= res_q;
            failed_q   <= fail_q;
            init_cmd_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_vld_q;
  assign result_value_o = result_q;
  assign failed_o       = failed_q;

  a_fill_below_amount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> cnt_q < amt_q)
    else $error("fill count reached amount without finishing");

  a_mark_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MARK |-> (scan_q >= s_q) && (scan_q <= e_q))
    else $error("flag marking left the new block");

  a_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HDR |-> hc_q < 5'(HDR_WRITES))
    else $error("header write counter overran");

endmodule
